>>> hdl/grp_pkg.sv
// ----------------------------------------------------------------------------
// grp_pkg: shared types and constants for the greedy row packer
// Holds the item, result and handoff types and the register index codes.
// ----------------------------------------------------------------------------
package grp_pkg;

   localparam int GRP_MAX_ITEMS = 65536;

   localparam int WIDTH_W  = 16;
   localparam int INDEX_W  = 16;
   localparam int ROW_W    = 16;
   localparam int POS_W    = 32;
   localparam int TOTAL_W  = 17;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [POS_W-1:0] POS_SAT = '1;
   localparam logic [ROW_W-1:0] ROW_SAT = '1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CONTAINER_WIDTH = 2'd0,
      CSR_GAP             = 2'd1,
      CSR_ROW_HEIGHT      = 2'd2
   } csr_index_type;

   typedef enum logic {
      KIND_PLACEMENT = 1'b0,
      KIND_ROW       = 1'b1
   } kind_type;

   typedef struct packed {
      logic [WIDTH_W-1:0] natural_width;
      logic               final_item;
   } item_type;

   typedef struct packed {
      logic                 kind;
      logic [INDEX_W-1:0]   index;
      logic [ROW_W-1:0]     row_index;
      logic [POS_W-1:0]     x_pos;
      logic [POS_W-1:0]     extent;
      logic [TOTAL_W-1:0]   item_total;
      logic [POS_W-1:0]     y_pos;
      logic                 last;
   } result_type;

   // slot 0: record of a row closed by a wrap, slot 1: placement,
   // slot 2: record of the last row on a final item
   typedef struct packed {
      logic [2:0]            slot_vld;
      result_type [2:0]      slot;
   } bundle_type;

   typedef struct packed {
      logic                  wr_en;
      logic [CSR_IDX_W-1:0]  index;
      logic [CSR_DATA_W-1:0] data;
   } csr_type;

   function automatic logic [POS_W-1:0] sat_add(input logic [POS_W-1:0] a,
                                                  input logic [POS_W-1:0] b);
      logic [POS_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[POS_W] ? POS_SAT : s[POS_W-1:0];
   endfunction

endpackage

>>> hdl/grp_if.sv
// ----------------------------------------------------------------------------
// grp_if: request and response channels of the greedy row packer
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ----------------------------------------------------------------------------
interface grp_req_if;
   import grp_pkg::*;

   logic               valid;
   logic               ready;
   logic [WIDTH_W-1:0] natural_width;
   logic               final_item;

   modport source (output valid, output natural_width, output final_item, input ready);
   modport sink   (input valid, input natural_width, input final_item, output ready);
endinterface

interface grp_rsp_if;
   import grp_pkg::*;

   logic                 valid;
   logic                 ready;
   logic                 kind;
   logic [INDEX_W-1:0]   index;
   logic [ROW_W-1:0]     row_index;
   logic [POS_W-1:0]     x_pos;
   logic [POS_W-1:0]     extent;
   logic [TOTAL_W-1:0]   item_total;
   logic [POS_W-1:0]     y_pos;
   logic                 last;

   modport source (output valid, output kind, output index, output row_index,
                   output x_pos, output extent, output item_total, output y_pos,
                   output last, input ready);
   modport sink   (input valid, input kind, input index, input row_index,
                   input x_pos, input extent, input item_total, input y_pos,
                   input last, output ready);
endinterface

>>> hdl/grp_in_stage.sv
// ----------------------------------------------------------------------------
// grp_in_stage: input register
// Captures one request item and holds it until the core takes it.
// ----------------------------------------------------------------------------
module grp_in_stage (
   input  logic              clock,
   input  logic              reset,
   grp_req_if.sink           req_ch,
   input  logic              take,
   output logic              item_vld,
   output grp_pkg::item_type item
);
   import grp_pkg::*;

   logic     vld_ff, vld_in;
   item_type item_ff, item_in;
   logic     load;

   assign req_ch.ready = !vld_ff || take;
   assign load         = req_ch.valid && req_ch.ready;

   always_comb begin
      vld_in  = vld_ff;
      item_in = item_ff;
      if (load) begin
         vld_in                = 1'b1;
         item_in.natural_width = req_ch.natural_width;
         item_in.final_item    = req_ch.final_item;
      end else if (take) begin
         vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
      item_ff <= item_in;
   end

   assign item_vld = vld_ff;
   assign item     = item_ff;
endmodule

>>> hdl/grp_core.sv
// ----------------------------------------------------------------------------
// grp_core: row packing step
// Holds the registers and list state, and turns one item into its results.
// ----------------------------------------------------------------------------
module grp_core #(
   parameter int MAX_ITEMS = grp_pkg::GRP_MAX_ITEMS
) (
   input  logic                clock,
   input  logic                reset,
   input  grp_pkg::csr_type    csr,
   input  grp_pkg::item_type   item,
   input  logic                take,
   output grp_pkg::bundle_type bundle
);
   import grp_pkg::*;

   localparam logic [TOTAL_W-1:0] ITEMS_SAT = TOTAL_W'(MAX_ITEMS);
   localparam logic [INDEX_W-1:0] INDEX_SAT = INDEX_W'(MAX_ITEMS - 1);

   logic [WIDTH_W-1:0] cw_ff, gap_ff, rh_ff;

   logic [POS_W-1:0]   x_ff, x_in;
   logic [INDEX_W-1:0] first_ff, first_in;
   logic [TOTAL_W-1:0] items_ff, items_in;
   logic [ROW_W-1:0]   row_ff, row_in;
   logic [POS_W-1:0]   y_ff, y_in;
   logic [INDEX_W-1:0] count_ff, count_in;

   logic [WIDTH_W-1:0] w;
   logic               wrap;
   logic [POS_W-1:0]   x1, x2, y1;
   logic [INDEX_W-1:0] first1, count2;
   logic [TOTAL_W-1:0] items1, items2;
   logic [ROW_W-1:0]   row1;
   logic [POS_W-1:0]   wrap_extent, fin_extent;
   logic [WIDTH_W:0]   step_y, step_x;

   always_ff @(posedge clock) begin
      if (reset) begin
         cw_ff  <= '0;
         gap_ff <= '0;
         rh_ff  <= '0;
      end else if (csr.wr_en) begin
         unique case (csr.index)
            CSR_CONTAINER_WIDTH: cw_ff  <= csr.data;
            CSR_GAP:             gap_ff <= csr.data;
            CSR_ROW_HEIGHT:      rh_ff  <= csr.data;
            default: ;
         endcase
      end
   end

   always_comb begin
      w = item.natural_width;
      if (cw_ff != '0 && item.natural_width > cw_ff) begin
         w = cw_ff;
      end
      wrap = (cw_ff != '0) && (items_ff != '0) &&
             (({1'b0, x_ff} + (POS_W+1)'(w)) > (POS_W+1)'(cw_ff));

      wrap_extent = (x_ff > POS_W'(gap_ff)) ? x_ff - POS_W'(gap_ff) : '0;
      step_y      = (WIDTH_W+1)'(rh_ff) + (WIDTH_W+1)'(gap_ff);
      step_x      = (WIDTH_W+1)'(w) + (WIDTH_W+1)'(gap_ff);

      // close the current row first when the item does not fit
      row1   = row_ff;
      y1     = y_ff;
      first1 = first_ff;
      items1 = items_ff;
      x1     = x_ff;
      if (wrap) begin
         row1   = (row_ff != ROW_SAT) ? row_ff + 1'b1 : row_ff;
         y1     = sat_add(y_ff, POS_W'(step_y));
         first1 = count_ff;
         items1 = '0;
         x1     = '0;
      end

      items2     = (items1 < ITEMS_SAT) ? items1 + 1'b1 : items1;
      x2         = sat_add(x1, POS_W'(step_x));
      count2     = (count_ff < INDEX_SAT) ? count_ff + 1'b1 : count_ff;
      fin_extent = (x2 > POS_W'(gap_ff)) ? x2 - POS_W'(gap_ff) : '0;
   end

   always_comb begin
      bundle.slot_vld = {item.final_item, 1'b1, wrap};

      bundle.slot[0].kind       = KIND_ROW;
      bundle.slot[0].index      = first_ff;
      bundle.slot[0].row_index  = row_ff;
      bundle.slot[0].x_pos      = '0;
      bundle.slot[0].extent     = wrap_extent;
      bundle.slot[0].item_total = items_ff;
      bundle.slot[0].y_pos      = y_ff;
      bundle.slot[0].last       = 1'b0;

      bundle.slot[1].kind       = KIND_PLACEMENT;
      bundle.slot[1].index      = count_ff;
      bundle.slot[1].row_index  = row1;
      bundle.slot[1].x_pos      = x1;
      bundle.slot[1].extent     = POS_W'(w);
      bundle.slot[1].item_total = '0;
      bundle.slot[1].y_pos      = y1;
      bundle.slot[1].last       = !item.final_item;

      bundle.slot[2].kind       = KIND_ROW;
      bundle.slot[2].index      = first1;
      bundle.slot[2].row_index  = row1;
      bundle.slot[2].x_pos      = '0;
      bundle.slot[2].extent     = fin_extent;
      bundle.slot[2].item_total = items2;
      bundle.slot[2].y_pos      = y1;
      bundle.slot[2].last       = 1'b1;
   end

   always_comb begin
      x_in     = x_ff;
      first_in = first_ff;
      items_in = items_ff;
      row_in   = row_ff;
      y_in     = y_ff;
      count_in = count_ff;
      if (take) begin
         if (item.final_item) begin
            // end of list: start over
            x_in     = '0;
            first_in = '0;
            items_in = '0;
            row_in   = '0;
            y_in     = '0;
            count_in = '0;
         end else begin
            x_in     = x2;
            first_in = first1;
            items_in = items2;
            row_in   = row1;
            y_in     = y1;
            count_in = count2;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_ff     <= '0;
         first_ff <= '0;
         items_ff <= '0;
         row_ff   <= '0;
         y_ff     <= '0;
         count_ff <= '0;
      end else begin
         x_ff     <= x_in;
         first_ff <= first_in;
         items_ff <= items_in;
         row_ff   <= row_in;
         y_ff     <= y_in;
         count_ff <= count_in;
      end
   end
endmodule

>>> hdl/grp_out_seq.sv
// ----------------------------------------------------------------------------
// grp_out_seq: result register and sequencer
// Holds the results of one item and sends them one per transfer, in order.
// ----------------------------------------------------------------------------
module grp_out_seq (
   input  logic                clock,
   input  logic                reset,
   input  grp_pkg::bundle_type bundle,
   input  logic                take,
   output logic                can_take,
   grp_rsp_if.source           rsp_ch
);
   import grp_pkg::*;

   logic [2:0]       pend_ff, pend_in;
   result_type [2:0] slot_ff, slot_in;
   result_type       cur;
   logic [2:0]       cur_bit;
   logic             xfer;

   always_comb begin
      cur     = slot_ff[2];
      cur_bit = 3'b100;
      priority if (pend_ff[0]) begin
         cur     = slot_ff[0];
         cur_bit = 3'b001;
      end else if (pend_ff[1]) begin
         cur     = slot_ff[1];
         cur_bit = 3'b010;
      end
   end

   assign xfer     = rsp_ch.valid && rsp_ch.ready;
   // free now, or the last pending result leaves this cycle
   assign can_take = (pend_ff == '0) || (xfer && $onehot(pend_ff));

   always_comb begin
      pend_in = pend_ff;
      slot_in = slot_ff;
      if (take) begin
         pend_in = bundle.slot_vld;
         slot_in = bundle.slot;
      end else if (xfer) begin
         pend_in = pend_ff & ~cur_bit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
      slot_ff <= slot_in;
   end

   assign rsp_ch.valid      = (pend_ff != '0);
   assign rsp_ch.kind       = cur.kind;
   assign rsp_ch.index      = cur.index;
   assign rsp_ch.row_index  = cur.row_index;
   assign rsp_ch.x_pos      = cur.x_pos;
   assign rsp_ch.extent     = cur.extent;
   assign rsp_ch.item_total = cur.item_total;
   assign rsp_ch.y_pos      = cur.y_pos;
   assign rsp_ch.last       = cur.last;
endmodule

>>> hdl/greedy_row_packer_top.sv
// ----------------------------------------------------------------------------
// greedy_row_packer_top: next-fit row packer for a stream of item widths
//
//   channel  dir  payload                                         handshake
//   req_ch   in   natural_width, final_item                       valid/ready
//   rsp_ch   out  kind, index, row_index, x_pos, extent,          valid/ready
//                 item_total, y_pos, last
//   csr_*    in   csr_index, csr_wr_data                          csr_wr_en
//
// Each item gives one to three results, one per cycle on rsp_ch while its
// receiver is ready. The next item enters the result register as the last
// result of the previous one transfers. A request passes the input register
// and then the result register before its first result shows on rsp_ch.
// Synchronous reset clears registers and list state; there is no clearing
// pass. A stalled rsp_ch holds its result and backs up req_ch.
// ----------------------------------------------------------------------------
module greedy_row_packer_top #(
   parameter int MAX_ITEMS = grp_pkg::GRP_MAX_ITEMS
) (
   input  logic                              clock,
   input  logic                              reset,
   grp_req_if.sink                           req_ch,
   grp_rsp_if.source                         rsp_ch,
   input  logic                              csr_wr_en,
   input  logic [grp_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [grp_pkg::CSR_DATA_W-1:0]    csr_wr_data
);
   import grp_pkg::*;

   item_type   item;
   logic       item_vld;
   logic       can_take;
   logic       take;
   bundle_type bundle;
   csr_type    csr;

   assign csr.wr_en = csr_wr_en;
   assign csr.index = csr_index;
   assign csr.data  = csr_wr_data;

   assign take = item_vld && can_take;

   grp_in_stage u_in (
      .clock    (clock),
      .reset    (reset),
      .req_ch   (req_ch),
      .take     (take),
      .item_vld (item_vld),
      .item     (item)
   );

   grp_core #(
      .MAX_ITEMS (MAX_ITEMS)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .csr    (csr),
      .item   (item),
      .take   (take),
      .bundle (bundle)
   );

   grp_out_seq u_out (
      .clock    (clock),
      .reset    (reset),
      .bundle   (bundle),
      .take     (take),
      .can_take (can_take),
      .rsp_ch   (rsp_ch)
   );
endmodule

>>> hdl/grp_checker.sv
// ----------------------------------------------------------------------------
// grp_checker: port checks for the greedy row packer
// Watches the response channel for ordering of the results of one item.
// ----------------------------------------------------------------------------
module grp_checker (
   input logic clock,
   input logic reset,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_kind,
   input logic rsp_last
);
   import grp_pkg::*;

   // results come out of reset empty
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response valid dropped while stalled");

   // results of one item follow each other without a gap
   a_burst: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=> rsp_valid)
      else $error("gap inside the results of one item");

   // a row record that is not last was closed by a wrap: a placement follows
   a_wrap_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_kind == KIND_ROW && !rsp_last
      |=> rsp_valid && rsp_kind == KIND_PLACEMENT)
      else $error("wrap record not followed by a placement");
endmodule

bind greedy_row_packer_top grp_checker u_grp_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_kind  (rsp_ch.kind),
   .rsp_last  (rsp_ch.last)
);

>>> verif/greedy_row_packer_checker.sv
// ----------------------------------------------------------------------------
// greedy_row_packer_checker: result predictor and comparator for the row packer
// Watches the register port and both channels, works out the placements and
// row records that each accepted item must produce, and compares every result
// transfer field by field against the oldest one still pending.
// ----------------------------------------------------------------------------
module greedy_row_packer_checker #(
   parameter int MAX_ITEMS = grp_pkg::GRP_MAX_ITEMS
) (
   input  logic                           clock,
   input  logic                           reset,
   grp_req_if                             req_mon,
   grp_rsp_if                             rsp_mon,
   input  logic                           csr_wr_en,
   input  logic [grp_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [grp_pkg::CSR_DATA_W-1:0] csr_wr_data,
   output int                             error_count,
   output int                             outstanding,
   output int                             results_seen,
   output int                             rows_seen
);
   import grp_pkg::*;

   localparam int REPORT_LIMIT = 10;

   // register copies
   logic [CSR_DATA_W-1:0] limit_width;
   logic [CSR_DATA_W-1:0] spacing;
   logic [CSR_DATA_W-1:0] line_height;

   // list state
   logic [POS_W-1:0]   cursor_x;
   logic [POS_W-1:0]   row_top;
   logic [INDEX_W-1:0] row_start;
   logic [INDEX_W-1:0] next_index;
   logic [TOTAL_W-1:0] row_fill;
   logic [ROW_W-1:0]   row_no;

   result_type pending_layout[$];

   function automatic logic [POS_W-1:0] clip_add(input logic [POS_W-1:0] a,
                                                 input logic [POS_W-1:0] b);
      return (a > ~b) ? POS_SAT : a + b;
   endfunction

   task automatic clear_list();
      cursor_x   = '0;
      row_top    = '0;
      row_start  = '0;
      next_index = '0;
      row_fill   = '0;
      row_no     = '0;
   endtask

   task automatic close_row(input logic is_last);
      result_type rec;
      rec.kind       = KIND_ROW;
      rec.index      = row_start;
      rec.row_index  = row_no;
      rec.x_pos      = '0;
      // drop the trailing spacing, floor at zero
      rec.extent     = (cursor_x > POS_W'(spacing)) ? cursor_x - POS_W'(spacing) : '0;
      rec.item_total = row_fill;
      rec.y_pos      = row_top;
      rec.last       = is_last;
      pending_layout.push_back(rec);
   endtask

   task automatic place_item(input logic [WIDTH_W-1:0] raw_width, input logic fin);
      logic [WIDTH_W-1:0] w;
      result_type         pl;
      w = (limit_width != 0 && raw_width > limit_width) ? limit_width : raw_width;
      if (limit_width != 0 && row_fill != 0 &&
          ({1'b0, cursor_x} + (POS_W+1)'(w)) > (POS_W+1)'(limit_width)) begin
         close_row(1'b0);
         if (row_no != ROW_SAT) row_no = row_no + 1'b1;
         row_top   = clip_add(row_top, POS_W'(line_height) + POS_W'(spacing));
         row_start = next_index;
         row_fill  = '0;
         cursor_x  = '0;
      end
      pl.kind       = KIND_PLACEMENT;
      pl.index      = next_index;
      pl.row_index  = row_no;
      pl.x_pos      = cursor_x;
      pl.extent     = POS_W'(w);
      pl.item_total = '0;
      pl.y_pos      = row_top;
      pl.last       = !fin;
      pending_layout.push_back(pl);
      if (row_fill < TOTAL_W'(MAX_ITEMS)) row_fill = row_fill + 1'b1;
      cursor_x = clip_add(cursor_x, POS_W'(w) + POS_W'(spacing));
      if (next_index < INDEX_W'(MAX_ITEMS - 1)) next_index = next_index + 1'b1;
      if (fin) begin
         close_row(1'b1);
         clear_list();
      end
   endtask

   always @(posedge clock) begin
      result_type got;
      result_type want;
      string      bad;
      if (reset) begin
         limit_width = '0;
         spacing     = '0;
         line_height = '0;
         clear_list();
         pending_layout.delete();
         error_count  = 0;
         results_seen = 0;
         rows_seen    = 0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_CONTAINER_WIDTH: limit_width = csr_wr_data;
               CSR_GAP:             spacing     = csr_wr_data;
               CSR_ROW_HEIGHT:      line_height = csr_wr_data;
               default: ;
            endcase
         end

         // results of this edge always belong to earlier items: check before predicting
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.kind       = rsp_mon.kind;
            got.index      = rsp_mon.index;
            got.row_index  = rsp_mon.row_index;
            got.x_pos      = rsp_mon.x_pos;
            got.extent     = rsp_mon.extent;
            got.item_total = rsp_mon.item_total;
            got.y_pos      = rsp_mon.y_pos;
            got.last       = rsp_mon.last;
            results_seen++;
            if (got.kind == KIND_ROW) rows_seen++;
            if (pending_layout.size() == 0) begin
               error_count++;
               if (error_count <= REPORT_LIMIT)
                  $display("unexpected result %0d: kind=%0d index=%0d row=%0d",
                           results_seen, got.kind, got.index, got.row_index);
            end else begin
               want = pending_layout.pop_front();
               bad  = "";
               if (got.kind       !== want.kind)       bad = {bad, " kind"};
               if (got.index      !== want.index)      bad = {bad, " index"};
               if (got.row_index  !== want.row_index)  bad = {bad, " row_index"};
               if (got.x_pos      !== want.x_pos)      bad = {bad, " x_pos"};
               if (got.extent     !== want.extent)     bad = {bad, " extent"};
               if (got.item_total !== want.item_total) bad = {bad, " item_total"};
               if (got.y_pos      !== want.y_pos)      bad = {bad, " y_pos"};
               if (got.last       !== want.last)       bad = {bad, " last"};
               if (bad != "") begin
                  error_count++;
                  if (error_count <= REPORT_LIMIT) begin
                     $display("mismatch on result %0d:%s", results_seen, bad);
                     $display(
                        "  expected kind=%0d index=%0d row=%0d x=%h ext=%h total=%0d y=%h last=%0d",
                        want.kind, want.index, want.row_index, want.x_pos,
                        want.extent, want.item_total, want.y_pos, want.last);
                     $display(
                        "  actual   kind=%0d index=%0d row=%0d x=%h ext=%h total=%0d y=%h last=%0d",
                        got.kind, got.index, got.row_index, got.x_pos,
                        got.extent, got.item_total, got.y_pos, got.last);
                  end
               end
            end
         end

         if (req_mon.valid && req_mon.ready)
            place_item(req_mon.natural_width, req_mon.final_item);
      end
      outstanding = pending_layout.size();
   end

endmodule

>>> verif/greedy_row_packer_top_test.sv
// ----------------------------------------------------------------------------
// greedy_row_packer_top_test: stimulus and verdict for the row packer
// Drives item lists under several register settings and flow-control mixes,
// including a long receiver hold-off and a drain pause. The checker beside
// the block does all prediction and comparison.
// ----------------------------------------------------------------------------
module greedy_row_packer_top_test;
   import grp_pkg::*;

   localparam int PACK_LIMIT     = GRP_MAX_ITEMS;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int TAIL_CYCLES    = 12;
   localparam int PHASE_ITEMS    = 44;
   localparam int HOLD_CYCLES    = 240;
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED = 2'd3;

   logic                  clock;
   logic                  reset;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wr_data;

   int error_count;
   int outstanding;
   int results_seen;
   int rows_seen;

   int send_idle_pct;
   int stall_pct;
   int hold_left;
   int idle_run;
   int items_sent;
   int settings_used;
   logic [CSR_DATA_W-1:0] cur_width;

   grp_req_if req_ch();
   grp_rsp_if rsp_ch();

   greedy_row_packer_top #(.MAX_ITEMS(PACK_LIMIT)) dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   greedy_row_packer_checker #(.MAX_ITEMS(PACK_LIMIT)) packer_check (
      .clock        (clock),
      .reset        (reset),
      .req_mon      (req_ch),
      .rsp_mon      (rsp_ch),
      .csr_wr_en    (csr_wr_en),
      .csr_index    (csr_index),
      .csr_wr_data  (csr_wr_data),
      .error_count  (error_count),
      .outstanding  (outstanding),
      .results_seen (results_seen),
      .rows_seen    (rows_seen)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // receiver: a requested hold-off wins over random stalls
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_ch.ready <= 1'b0;
         hold_left = hold_left - 1;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_run = 0;
         else
            idle_run = idle_run + 1;
         if (idle_run >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", idle_run);
            $display("greedy_row_packer_top_test: done, errors");
            $finish;
         end
      end
   end

   function automatic logic [CSR_DATA_W-1:0] pick_setting(input int span);
      int r;
      r = $urandom_range(9);
      if (r == 0) return '0;
      if (r == 1) return '1;
      if (r <= 3) return CSR_DATA_W'($urandom);
      return CSR_DATA_W'($urandom_range(1, span));
   endfunction

   task automatic send_item(input logic [WIDTH_W-1:0] w, input logic fin);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid         <= 1'b1;
      req_ch.natural_width <= w;
      req_ch.final_item    <= fin;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      @(negedge clock);
      items_sent++;
   endtask

   // always advance at least once so valid never gets two updates in one step
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      @(negedge clock);
      while (outstanding != 0) @(negedge clock);
   endtask

   task automatic settle();
      wait_drained();
      repeat (4) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= val;
      @(negedge clock);
   endtask

   // the unmapped index gets junk every time; it must be ignored
   task automatic apply_settings(input logic [CSR_DATA_W-1:0] cw,
                                 input logic [CSR_DATA_W-1:0] gp,
                                 input logic [CSR_DATA_W-1:0] rh);
      write_csr(CSR_CONTAINER_WIDTH, cw);
      write_csr(CSR_GAP, gp);
      write_csr(CSR_ROW_HEIGHT, rh);
      write_csr(CSR_UNMAPPED, CSR_DATA_W'($urandom));
      csr_wr_en <= 1'b0;
      cur_width = cw;
      settings_used++;
   endtask

   // lists of random length; a stray final ends one early, and the budget may
   // leave the last list open across the next register write
   task automatic send_lists(input int count);
      int n;
      int len;
      int pos;
      int r;
      int top;
      logic [WIDTH_W-1:0] w;
      logic fin;
      n = 0;
      while (n < count) begin
         len = ($urandom_range(7) != 0) ? $urandom_range(1, 10) : $urandom_range(11, 40);
         for (pos = 0; pos < len && n < count; pos++) begin
            r   = $urandom_range(99);
            top = (cur_width == 0) ? 3000 : int'(cur_width) + int'(cur_width) / 4 + 1;
            if (top > 65535) top = 65535;
            if (r < 10)      w = WIDTH_W'($urandom);
            else if (r < 14) w = '0;
            else if (r < 18) w = '1;
            else             w = WIDTH_W'($urandom_range(0, top));
            fin = (pos == len - 1) || ($urandom_range(49) == 0);
            send_item(w, fin);
            n++;
         end
      end
   endtask

   initial begin
      int sub;
      reset                = 1'b1;
      csr_wr_en            = 1'b0;
      csr_index            = '0;
      csr_wr_data          = '0;
      req_ch.valid         = 1'b0;
      req_ch.natural_width = '0;
      req_ch.final_item    = 1'b0;
      rsp_ch.ready         = 1'b0;
      hold_left            = 0;
      send_idle_pct        = 0;
      stall_pct            = 0;
      idle_run             = 0;
      items_sent           = 0;
      settings_used        = 1;
      cur_width            = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset settings: no wrapping, no clamping
      send_item(16'd0, 1'b0);
      send_item(16'hFFFF, 1'b0);
      send_item(16'd1234, 1'b1);

      // plain wrap, clamp with wrap, wrap on the final item, single-item list
      settle();
      apply_settings(16'd100, 16'd16, 16'd32);
      send_item(16'd40, 1'b0);
      send_item(16'd40, 1'b0);
      send_item(16'd40, 1'b0);
      send_item(16'd200, 1'b0);
      send_item(16'd100, 1'b1);
      send_item(16'd5, 1'b1);

      settle();
      apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_item(16'hFFFF, 1'b0);
      send_item(16'hFFFF, 1'b0);
      send_item(16'd0, 1'b0);
      send_item(16'd0, 1'b1);

      // exact fit does not wrap, one past it does
      settle();
      apply_settings(16'd1, 16'd0, 16'd1);
      send_item(16'd0, 1'b0);
      send_item(16'd0, 1'b0);
      send_item(16'd1, 1'b0);
      send_item(16'd1, 1'b0);
      send_item(16'hFFFF, 1'b0);
      send_item(16'd0, 1'b1);

      settle();
      apply_settings(16'd0, 16'hFFFF, 16'hFFFF);
      send_item(16'hFFFF, 1'b0);
      send_item(16'hFFFF, 1'b1);

      for (sub = 0; sub < 8; sub++) begin
         settle();
         case (sub / 2)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 84; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 84; end
            default: begin send_idle_pct = 20; stall_pct = 20; end
         endcase
         if (sub == 2)
            apply_settings(16'hFFFF, 16'd0, 16'hFFFF);
         else if (sub == 5)
            apply_settings(16'd1, 16'hFFFF, 16'd0);
         else
            apply_settings(pick_setting(1600), pick_setting(48), pick_setting(400));
         if (sub == 0) begin
            // hold the receiver while items keep coming, so the block backs up
            hold_left = HOLD_CYCLES;
            send_lists(24);
            send_lists(PHASE_ITEMS - 24);
         end else if (sub == 3) begin
            send_lists(PHASE_ITEMS / 2);
            wait_drained();
            send_lists(PHASE_ITEMS / 2);
         end else begin
            send_lists(PHASE_ITEMS);
         end
      end

      wait_drained();
      repeat (TAIL_CYCLES) @(negedge clock);

      $display("covered %0d items under %0d register settings and four flow-control mixes",
               items_sent, settings_used);
      $display("checked %0d results (%0d row records), with a long hold-off and a drain pause",
               results_seen, rows_seen);
      if (error_count == 0 && outstanding == 0) begin
         $display("greedy_row_packer_top_test: done, clean");
      end else begin
         $display("failures: %0d, results still pending: %0d", error_count, outstanding);
         $display("greedy_row_packer_top_test: done, errors");
      end
      $finish;
   end

endmodule

>>> sim.f
hdl/grp_pkg.sv
hdl/grp_if.sv
hdl/grp_in_stage.sv
hdl/grp_core.sv
hdl/grp_out_seq.sv
hdl/greedy_row_packer_top.sv
hdl/grp_checker.sv
verif/greedy_row_packer_checker.sv
verif/greedy_row_packer_top_test.sv
